// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Both expect a clock named clk and an active-low synchronous reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pcss_pkg.sv
package pcss_pkg;

  localparam int TICK_BITS_DEF  = 24;
  localparam int GROUP_SIZE_DEF = 4;

  localparam int CH_W     = 4;
  localparam int TICKS_W  = 24;
  localparam int SLOT_W   = 2;
  localparam int DUTY_W   = 10;
  localparam int FREQ_W   = 26;
  localparam int PRESC_W  = 17;
  localparam int THR_W    = 10;

  // Shared divider: quotient register and step counter widths
  localparam int DIV_QW   = 27;
  localparam int DIV_SW   = 5;

  localparam logic [DIV_QW-1:0] TIMER_CLOCK = DIV_QW'(72000000);
  localparam int                PERMILLE    = 1000;

  localparam logic [PRESC_W-1:0] PRESC_RST = PRESC_W'(1);
  localparam logic [THR_W-1:0]   THR_RST   = THR_W'(500);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic               high_phase_ended;
    logic [TICKS_W-1:0] ticks;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] pwm_slot;
    logic [DUTY_W-1:0] duty_permille;
    logic [FREQ_W-1:0] frequency_hz;
    logic              from_remote;
  } out_item_t;

  typedef struct packed {
    logic [PRESC_W-1:0] prescale;
    logic [THR_W-1:0]   select_threshold;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DUTY_GO,
    ST_DUTY_WAIT,
    ST_FRQ1_GO,
    ST_FRQ1_WAIT,
    ST_FRQ2_GO,
    ST_FRQ2_WAIT,
    ST_EMIT
  } seq_state_t;

endpackage

// File: sv/pcss_div.sv
module pcss_div #(
  parameter int DW = pcss_pkg::TICK_BITS_DEF + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DW-1:0]               rem_init,
  input  logic [pcss_pkg::DIV_QW-1:0] dividend,
  input  logic [pcss_pkg::DIV_SW-1:0] steps,
  input  logic [DW-1:0]               divisor,
  output logic                        done,
  output logic [pcss_pkg::DIV_QW-1:0] quotient
);

  `include "assert_macros.svh"

  localparam int QW = pcss_pkg::DIV_QW;
  localparam int SW = pcss_pkg::DIV_SW;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] sr_r, sr_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [DW-1:0] div_r, div_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [DW:0] trial;
  logic [DW:0] dvx;
  logic [DW:0] diff;
  logic        ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, sr_r[QW-1]};
  assign dvx   = {1'b0, div_r};
  assign diff  = trial - dvx;
  assign ge    = trial >= dvx;

  always_comb begin
    rem_nxt  = rem_r;
    sr_nxt   = sr_r;
    q_nxt    = q_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      sr_nxt   = dividend;
      q_nxt    = '0;
      div_nxt  = divisor;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      sr_nxt  = {sr_r[QW-2:0], 1'b0};
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sr_r  <= sr_nxt;
    q_r   <= q_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  `ASSERT_NOW(a_start_idle, start, !busy_r, "divider started while busy")
  `ASSERT_NOW(a_done_after_busy, done_r, $past(busy_r), "done without a running division")
  `ASSERT_NOW(a_busy_count, busy_r, cnt_r != '0, "divider busy with no steps left")

endmodule

// File: sv/pcss_seq.sv
module pcss_seq #(
  parameter int TICK_BITS  = pcss_pkg::TICK_BITS_DEF,
  parameter int GROUP_SIZE = pcss_pkg::GROUP_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pcss_pkg::cfg_regs_t cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcss_pkg::out_item_t out_data
);

  `include "assert_macros.svh"

  localparam int TW    = TICK_BITS;
  localparam int DW    = TICK_BITS + 1;
  localparam int PW    = TICK_BITS + pcss_pkg::DUTY_W;
  localparam int NCH   = 2 * GROUP_SIZE + 1;
  localparam int IW    = $clog2(NCH);
  localparam int QW    = pcss_pkg::DIV_QW;
  localparam int SW    = pcss_pkg::DIV_SW;
  localparam int CW    = pcss_pkg::CH_W;
  localparam int DTW   = pcss_pkg::DUTY_W;
  localparam int FW    = pcss_pkg::FREQ_W;

  pcss_pkg::seq_state_t state_r, state_nxt;

  logic [TW-1:0]  high_r [NCH];
  logic [TW-1:0]  low_r  [NCH];
  logic [FW-1:0]  lead_freq_r [2];

  logic [TW-1:0]  hi_r, hi_nxt;
  logic [TW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  ch_r, ch_nxt;
  logic [PW-1:0]  prod_r, prod_nxt;
  logic [DW-1:0]  period_r, period_nxt;
  logic [DTW-1:0] duty_r, duty_nxt;
  logic [QW-1:0]  q1_r, q1_nxt;
  logic           remote_r, remote_nxt;
  logic           out_valid_r, out_valid_nxt;
  pcss_pkg::out_item_t out_data_r, out_data_nxt;

  // time store write port
  logic           tw_en;
  logic [IW-1:0]  tw_idx;
  logic [TW-1:0]  tw_hi;
  logic [TW-1:0]  tw_lo;
  // leader frequency write port
  logic           lf_en;
  logic           lf_idx;
  logic [FW-1:0]  lf_val;

  logic           accept;
  logic           ch_ok;
  logic [IW-1:0]  idx;
  logic [TW-1:0]  tk;
  logic [TW-1:0]  new_hi;
  logic [TW-1:0]  new_lo;
  logic           complete;
  logic           is_remote;
  logic [CW-1:0]  pos;
  logic           out_free;

  logic           div_start;
  logic [DW-1:0]  div_rem;
  logic [QW-1:0]  div_dvd;
  logic [SW-1:0]  div_steps;
  logic [DW-1:0]  div_dvs;
  logic           div_done;
  logic [QW-1:0]  div_q;
  logic [pcss_pkg::PRESC_W-1:0] presc_eff;

  assign in_stall = (state_r != pcss_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ch_ok    = int'(in_data.channel) < NCH;
  assign idx      = IW'(in_data.channel);
  assign tk       = TW'(in_data.ticks);
  assign new_hi   = in_data.high_phase_ended ? tk : high_r[idx];
  assign new_lo   = in_data.high_phase_ended ? low_r[idx] : tk;
  assign complete = (new_hi != '0) && (new_lo != '0);

  // group and slot of the held channel; only meaningful for channels above zero
  assign is_remote = ch_r <= CW'(GROUP_SIZE);
  assign pos       = ch_r - CW'(1) - (is_remote ? CW'(0) : CW'(GROUP_SIZE));
  assign out_free  = !out_valid_r || !out_stall;
  assign presc_eff = (cfg.prescale == '0) ? pcss_pkg::PRESC_W'(1) : cfg.prescale;

  // divider operands per phase
  always_comb begin
    div_rem   = '0;
    div_dvd   = '0;
    div_steps = SW'(QW);
    div_dvs   = period_r;
    case (state_r)
      pcss_pkg::ST_DUTY_GO: begin
        // high*1000 < period*1024, so the upper part is already below the divisor
        div_rem   = {1'b0, prod_r[PW-1:DTW]};
        div_dvd   = {prod_r[DTW-1:0], (QW-DTW)'(0)};
        div_steps = SW'(DTW);
      end
      pcss_pkg::ST_FRQ1_GO: begin
        div_dvd = pcss_pkg::TIMER_CLOCK;
        div_dvs = DW'(presc_eff);
      end
      pcss_pkg::ST_FRQ2_GO: begin
        div_dvd = q1_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    ch_nxt        = ch_r;
    prod_nxt      = prod_r;
    period_nxt    = period_r;
    duty_nxt      = duty_r;
    q1_nxt        = q1_r;
    remote_nxt    = remote_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    tw_en         = 1'b0;
    tw_idx        = idx;
    tw_hi         = new_hi;
    tw_lo         = new_lo;
    lf_en         = 1'b0;
    lf_idx        = is_remote;
    lf_val        = div_q[FW-1:0];
    div_start     = 1'b0;
    case (state_r)
      pcss_pkg::ST_IDLE: begin
        if (accept && ch_ok) begin
          tw_en  = 1'b1;
          hi_nxt = new_hi;
          lo_nxt = new_lo;
          ch_nxt = in_data.channel;
          if (complete) begin
            // period done: clear both times now, work from the held copy
            tw_hi     = '0;
            tw_lo     = '0;
            state_nxt = pcss_pkg::ST_MUL;
          end
        end
      end
      pcss_pkg::ST_MUL: begin
        prod_nxt   = PW'(hi_r) * PW'(pcss_pkg::PERMILLE);
        period_nxt = {1'b0, hi_r} + {1'b0, lo_r};
        state_nxt  = pcss_pkg::ST_DUTY_GO;
      end
      pcss_pkg::ST_DUTY_GO: begin
        div_start = 1'b1;
        state_nxt = pcss_pkg::ST_DUTY_WAIT;
      end
      pcss_pkg::ST_DUTY_WAIT: begin
        if (div_done) begin
          duty_nxt = div_q[DTW-1:0];
          if (ch_r == '0) begin
            remote_nxt = div_q[DTW-1:0] > cfg.select_threshold;
            state_nxt  = pcss_pkg::ST_IDLE;
          end else if (pos == '0) begin
            state_nxt = pcss_pkg::ST_FRQ1_GO;
          end else if (is_remote == remote_r) begin
            state_nxt = pcss_pkg::ST_EMIT;
          end else begin
            state_nxt = pcss_pkg::ST_IDLE;
          end
        end
      end
      pcss_pkg::ST_FRQ1_GO: begin
        div_start = 1'b1;
        state_nxt = pcss_pkg::ST_FRQ1_WAIT;
      end
      pcss_pkg::ST_FRQ1_WAIT: begin
        if (div_done) begin
          q1_nxt    = div_q;
          state_nxt = pcss_pkg::ST_FRQ2_GO;
        end
      end
      pcss_pkg::ST_FRQ2_GO: begin
        div_start = 1'b1;
        state_nxt = pcss_pkg::ST_FRQ2_WAIT;
      end
      pcss_pkg::ST_FRQ2_WAIT: begin
        if (div_done) begin
          lf_en     = 1'b1;
          state_nxt = (is_remote == remote_r) ? pcss_pkg::ST_EMIT : pcss_pkg::ST_IDLE;
        end
      end
      pcss_pkg::ST_EMIT: begin
        // hold until the output register can take the beat
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.pwm_slot      = pos[pcss_pkg::SLOT_W-1:0];
          out_data_nxt.duty_permille = duty_r;
          out_data_nxt.frequency_hz  = lead_freq_r[is_remote];
          out_data_nxt.from_remote   = is_remote;
          state_nxt                  = pcss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcss_pkg::ST_IDLE;
      remote_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      remote_r    <= remote_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        high_r[i] <= '0;
        low_r[i]  <= '0;
      end
      lead_freq_r[0] <= '0;
      lead_freq_r[1] <= '0;
    end else begin
      if (tw_en) begin
        high_r[tw_idx] <= tw_hi;
        low_r[tw_idx]  <= tw_lo;
      end
      if (lf_en) begin
        lead_freq_r[lf_idx] <= lf_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    ch_r       <= ch_nxt;
    prod_r     <= prod_nxt;
    period_r   <= period_nxt;
    duty_r     <= duty_nxt;
    q1_r       <= q1_nxt;
    out_data_r <= out_data_nxt;
  end

  pcss_div #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .steps    (div_steps),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NOW(a_done_in_wait, div_done, (state_r == pcss_pkg::ST_DUTY_WAIT) || (state_r == pcss_pkg::ST_FRQ1_WAIT) || (state_r == pcss_pkg::ST_FRQ2_WAIT), "divider result outside a wait phase")
  `ASSERT_NOW(a_duty_range, (state_r == pcss_pkg::ST_DUTY_WAIT) && div_done, div_q <= QW'(pcss_pkg::PERMILLE), "duty above 1000 per mille")
  `ASSERT_NEXT(a_emit_loads, (state_r == pcss_pkg::ST_EMIT) && out_free, out_valid_r && (state_r == pcss_pkg::ST_IDLE), "result not loaded when output free")

endmodule

// File: sv/pwm_capture_source_switch_top.sv
// PWM capture with source switching. Each input beat is one edge event of one
// of 2*GROUP_SIZE+1 channels; the block keeps each channel's last high and low
// time and, once both are nonzero, computes duty (per mille) and, for a group
// leader, frequency with one shared restoring divider running one quotient bit
// per cycle. After a completing event in_stall stays high through a multiply
// and 10 duty steps for channel 0 or a non-leader, and also through two more
// 27-step frequency divisions for a group leader; where a result is emitted,
// an emit state then loads it and waits while the previous result waits on
// out_stall. A result sits in an output register, so a stalled result holds
// the block only when the next result is ready. Configuration (prescale,
// select_threshold) must be written through cfg_* only while the block is idle;
// the block itself does not enforce this, and cfg_ready is always high.
module pwm_capture_source_switch_top #(
  parameter int TICK_BITS  = pcss_pkg::TICK_BITS_DEF,
  parameter int GROUP_SIZE = pcss_pkg::GROUP_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcss_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcss_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcss_pkg::PRESC_W-1:0]        cfg_data
);

  pcss_pkg::cfg_regs_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        pcss_pkg::CFG_PRESCALE:  cfg_nxt.prescale = cfg_data;
        pcss_pkg::CFG_THRESHOLD: cfg_nxt.select_threshold = cfg_data[pcss_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prescale         <= pcss_pkg::PRESC_RST;
      cfg_r.select_threshold <= pcss_pkg::THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pcss_seq #(
    .TICK_BITS  (TICK_BITS),
    .GROUP_SIZE (GROUP_SIZE)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
